FILE: sv/ab2lp_pkg.sv
// ab2lp_pkg: shared types and codes for the annex b to length-prefixed converter
// no dependencies
package ab2lp_pkg;

	localparam int unsigned LEN_W = 32;

	localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
	localparam logic [1:0] KIND_UNIT_END   = 2'd1;
	localparam logic [1:0] KIND_PACKET_END = 2'd2;

	localparam logic [1:0] HOLD_FULL = 2'd3;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       record_kind;
		logic [7:0]       payload_byte;
		logic [LEN_W-1:0] unit_length;
		logic             run_last;
	} out_item_t;

	// everything one input byte produces, in emission order:
	// unit-end record, held zeros, the byte itself, packet-end record
	typedef struct packed {
		logic             ue;
		logic [LEN_W-1:0] ue_len;
		logic [2:0]       nzero;
		logic             byte_v;
		logic [7:0]       byte_val;
		logic             pe;
		logic [LEN_W-1:0] pe_len;
	} desc_t;

endpackage

FILE: sv/ab2lp_parse.sv
// ab2lp_parse: start code detection, zero hold and unit length count
// depends on ab2lp_pkg
module ab2lp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  ab2lp_pkg::in_item_t item,
	output ab2lp_pkg::desc_t    desc,
	output logic                desc_any
);

	logic [1:0]                  hold_q;
	logic                        inside_q;
	logic [ab2lp_pkg::LEN_W-1:0] count_q;

	logic                        is_sc;
	logic                        is_zero;
	logic [1:0]                  hold_mid;
	logic [1:0]                  z_main;
	logic [2:0]                  z_total;
	logic [2:0]                  added;
	logic                        inside_mid;
	logic [ab2lp_pkg::LEN_W:0]   sum;
	logic [ab2lp_pkg::LEN_W-1:0] count_mid;

	always_comb begin
		is_sc   = (item.data_byte == ab2lp_pkg::BYTE_ONE) && (hold_q >= 2'd2);
		is_zero = (item.data_byte == ab2lp_pkg::BYTE_ZERO);

		// zeros released by this byte and the hold level that remains
		if (is_sc) begin
			z_main   = 2'd0;
			hold_mid = 2'd0;
		end else if (is_zero) begin
			z_main   = (hold_q == ab2lp_pkg::HOLD_FULL) ? 2'd1 : 2'd0;
			hold_mid = (hold_q == ab2lp_pkg::HOLD_FULL) ? ab2lp_pkg::HOLD_FULL : hold_q + 2'd1;
		end else begin
			z_main   = hold_q;
			hold_mid = 2'd0;
		end

		inside_mid = is_sc | inside_q;

		// packet end flushes whatever is still held
		z_total = {1'b0, z_main} + (item.packet_last ? {1'b0, hold_mid} : 3'd0);
		if (!inside_q)
			z_total = 3'd0;

		desc.ue       = is_sc && inside_q && (count_q != '0);
		desc.ue_len   = count_q;
		desc.nzero    = z_total;
		desc.byte_v   = !is_sc && !is_zero && inside_q;
		desc.byte_val = item.data_byte;

		added = z_total + {2'b00, desc.byte_v};
		sum   = {1'b0, count_q} + {{(ab2lp_pkg::LEN_W-2){1'b0}}, added};
		if (is_sc)
			count_mid = '0;
		else if (sum[ab2lp_pkg::LEN_W])
			count_mid = '1;
		else
			count_mid = sum[ab2lp_pkg::LEN_W-1:0];

		desc.pe     = item.packet_last;
		desc.pe_len = inside_mid ? count_mid : '0;

		desc_any = desc.ue || (desc.nzero != 3'd0) || desc.byte_v || desc.pe;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= 2'd0;
			inside_q <= 1'b0;
			count_q  <= '0;
		end else if (accept) begin
			if (item.packet_last) begin
				hold_q   <= 2'd0;
				inside_q <= 1'b0;
				count_q  <= '0;
			end else begin
				hold_q   <= hold_mid;
				inside_q <= inside_mid;
				count_q  <= count_mid;
			end
		end
	end

endmodule

FILE: sv/ab2lp_emit.sv
// ab2lp_emit: holds one byte's pending results and sends them one per cycle while the output is not stalled
// depends on ab2lp_pkg
module ab2lp_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  ab2lp_pkg::desc_t     desc,
	output logic                 free,
	output logic                 result_valid,
	input  logic                 result_ready,
	output ab2lp_pkg::out_item_t result
);

	ab2lp_pkg::desc_t    desc_q;
	ab2lp_pkg::desc_t    rest;
	ab2lp_pkg::out_item_t nxt;
	ab2lp_pkg::out_item_t out_q;
	logic                out_valid_q;
	logic                pend;
	logic                rest_any;
	logic                step;

	always_comb begin
		pend = desc_q.ue || (desc_q.nzero != 3'd0) || desc_q.byte_v || desc_q.pe;
		rest = desc_q;
		nxt  = '0;
		if (desc_q.ue) begin
			nxt.record_kind = ab2lp_pkg::KIND_UNIT_END;
			nxt.unit_length = desc_q.ue_len;
			rest.ue         = 1'b0;
		end else if (desc_q.nzero != 3'd0) begin
			nxt.record_kind = ab2lp_pkg::KIND_PAYLOAD;
			rest.nzero      = desc_q.nzero - 3'd1;
		end else if (desc_q.byte_v) begin
			nxt.record_kind  = ab2lp_pkg::KIND_PAYLOAD;
			nxt.payload_byte = desc_q.byte_val;
			rest.byte_v      = 1'b0;
		end else begin
			nxt.record_kind = ab2lp_pkg::KIND_PACKET_END;
			nxt.unit_length = desc_q.pe_len;
			rest.pe         = 1'b0;
		end
		rest_any     = rest.ue || (rest.nzero != 3'd0) || rest.byte_v || rest.pe;
		nxt.run_last = !rest_any;

		step = pend && (!out_valid_q || result_ready);
		// a new request may enter once the last pending result moves out
		free = !pend || (step && !rest_any);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= '0;
		end else if (load) begin
			desc_q <= desc;
		end else if (step) begin
			desc_q <= rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= nxt;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: sv/annexb_to_length_prefixed.sv
// Annex B start-code stripper producing length-prefixed units. Takes one byte
// per cycle; each byte yields zero to five results, sent one per cycle through
// a result register while the output is not stalled, so the sustained input
// rate is one byte per cycle when each byte gives at most one result; a byte
// with more holds off the next until the single result register sends them. A unit's
// length arrives as a unit-end record after its bytes, and a packet-end record
// (carrying the final unit's length) follows each packet's last byte.
module annexb_to_length_prefixed (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  ab2lp_pkg::in_item_t  item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output ab2lp_pkg::out_item_t result
);

	ab2lp_pkg::desc_t desc;
	logic             desc_any;
	logic             accept;
	logic             free;

	assign item_ready = free;
	assign accept     = item_valid && free;

	ab2lp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.desc     (desc),
		.desc_any (desc_any)
	);

	ab2lp_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept && desc_any),
		.desc         (desc),
		.free         (free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: sv/ab2lp_checker.sv
// ab2lp_checker: port-level checks on the converter's result stream
// depends on ab2lp_pkg; bound to annexb_to_length_prefixed
module ab2lp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_ready,
	input logic                 result_valid,
	input logic                 result_ready,
	input ab2lp_pkg::out_item_t result
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// packet end is always the last result of its byte
	a_pe_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.record_kind == ab2lp_pkg::KIND_PACKET_END)
		|-> result.run_last)
		else $error("packet end not marked last");

	// empty units never report
	a_ue_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.record_kind == ab2lp_pkg::KIND_UNIT_END)
		|-> (result.unit_length != '0) && (result.payload_byte == 8'h00))
		else $error("bad unit-end record");

	// payload records carry no length
	a_pl_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.record_kind == ab2lp_pkg::KIND_PAYLOAD)
		|-> (result.unit_length == '0))
		else $error("payload record with length");

	// no request taken while a multi-result request is still draining, and
	// the unused code never shows
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.record_kind != 2'd3)
			&& (result_ready || result.run_last || !item_ready))
		else $error("unused record kind or request taken while draining");

endmodule

bind annexb_to_length_prefixed ab2lp_checker u_ab2lp_checker (.*);

FILE: tb/sv/testbench.sv
// testbench for annexb_to_length_prefixed: directed table, then random annex b packets
// depends on ab2lp_pkg for the request and result types and the record codes
`timescale 1ns / 100ps

module testbench;

	localparam int RANDOM_ITEMS = 320;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam int SCRIPT_LEN   = 25;

	typedef struct packed {
		ab2lp_pkg::in_item_t  stim;
		logic                 typed;
		ab2lp_pkg::out_item_t exp;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_ready;
	ab2lp_pkg::in_item_t  item;
	logic                 result_valid;
	logic                 result_ready;
	ab2lp_pkg::out_item_t result;

	// stripper state as the byte stream has left it; held bytes are always zeros
	int unsigned zero_run;
	logic        in_unit;
	logic [31:0] unit_len;

	ab2lp_pkg::out_item_t step_recs[$];
	ab2lp_pkg::out_item_t pending_records[$];
	ab2lp_pkg::in_item_t  stim_q[$];
	logic                 typed_use;
	ab2lp_pkg::out_item_t typed_rec;
	logic                 no_idle;
	int                   fault_count;
	int                   cycles;

	// directed requests; rows with typed set carry their single expected result
	row_t script [SCRIPT_LEN] = '{
		'{'{8'hFF, 1'b1}, 1'b1, '{ab2lp_pkg::KIND_PACKET_END, 8'h00, 32'd0, 1'b1}},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ONE, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ONE, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ONE, 1'b0}, 1'b1,
			'{ab2lp_pkg::KIND_PAYLOAD, ab2lp_pkg::BYTE_ONE, 32'd0, 1'b1}},
		'{'{8'hFF, 1'b0}, 1'b1, '{ab2lp_pkg::KIND_PAYLOAD, 8'hFF, 32'd0, 1'b1}},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b1,
			'{ab2lp_pkg::KIND_PAYLOAD, ab2lp_pkg::BYTE_ZERO, 32'd0, 1'b1}},
		'{'{ab2lp_pkg::BYTE_ONE, 1'b0}, 1'b1,
			'{ab2lp_pkg::KIND_UNIT_END, 8'h00, 32'd3, 1'b1}},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ONE, 1'b0}, 1'b0, '0},
		'{'{8'h80, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{8'h7F, 1'b1}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b0}, 1'b0, '0},
		'{'{ab2lp_pkg::BYTE_ONE, 1'b1}, 1'b1,
			'{ab2lp_pkg::KIND_PACKET_END, 8'h00, 32'd0, 1'b1}},
		'{'{ab2lp_pkg::BYTE_ZERO, 1'b1}, 1'b1,
			'{ab2lp_pkg::KIND_PACKET_END, 8'h00, 32'd0, 1'b1}}
	};

	annexb_to_length_prefixed i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void add_rec(input logic [1:0] kind, input logic [7:0] pb,
			input logic [31:0] len);
		step_recs.push_back('{kind, pb, len, 1'b0});
	endfunction

	// bytes outside a unit are dropped uncounted
	function automatic void add_payload(input logic [7:0] pb);
		if (in_unit) begin
			add_rec(ab2lp_pkg::KIND_PAYLOAD, pb, 32'd0);
			if (unit_len != 32'hFFFF_FFFF)
				unit_len = unit_len + 32'd1;
		end
	endfunction

	function automatic void flush_zeros();
		repeat (zero_run) add_payload(ab2lp_pkg::BYTE_ZERO);
		zero_run = 0;
	endfunction

	// fills step_recs with what one accepted byte produces
	function automatic void strip_byte(input ab2lp_pkg::in_item_t it);
		step_recs.delete();
		if (it.data_byte == ab2lp_pkg::BYTE_ONE && zero_run >= 2) begin
			zero_run = 0;
			if (in_unit && unit_len != 32'd0)
				add_rec(ab2lp_pkg::KIND_UNIT_END, 8'h00, unit_len);
			in_unit  = 1'b1;
			unit_len = 32'd0;
		end else if (it.data_byte == ab2lp_pkg::BYTE_ZERO) begin
			// a fourth zero pushes the oldest one out as payload
			if (zero_run >= 3) begin
				add_payload(ab2lp_pkg::BYTE_ZERO);
				zero_run = 2;
			end
			zero_run++;
		end else begin
			flush_zeros();
			add_payload(it.data_byte);
		end
		if (it.packet_last) begin
			flush_zeros();
			add_rec(ab2lp_pkg::KIND_PACKET_END, 8'h00, in_unit ? unit_len : 32'd0);
			in_unit  = 1'b0;
			unit_len = 32'd0;
		end
	endfunction

	function automatic void report_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0d: %s", cycles, msg);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0, 1: return ab2lp_pkg::BYTE_ZERO;
			2: return ab2lp_pkg::BYTE_ONE;
			3: return 8'h03;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// mostly well-formed packets with random payload, some pure noise
	task automatic queue_packet();
		logic [7:0] pkt[$];
		int plen;
		if ($urandom_range(9) < 2) begin
			plen = $urandom_range(12, 1);
			repeat (plen) pkt.push_back(pick_byte());
		end else begin
			repeat ($urandom_range(3)) pkt.push_back(pick_byte());
			repeat ($urandom_range(4, 1)) begin
				// a zero ahead of a four-byte code stays in the payload
				if ($urandom_range(7) == 0)
					pkt.push_back(ab2lp_pkg::BYTE_ZERO);
				if ($urandom_range(1) == 1)
					pkt.push_back(ab2lp_pkg::BYTE_ZERO);
				pkt.push_back(ab2lp_pkg::BYTE_ZERO);
				pkt.push_back(ab2lp_pkg::BYTE_ZERO);
				pkt.push_back(ab2lp_pkg::BYTE_ONE);
				plen = ($urandom_range(15) == 0) ? $urandom_range(80, 40) : $urandom_range(10);
				repeat (plen) pkt.push_back(pick_byte());
			end
		end
		foreach (pkt[k])
			stim_q.push_back('{pkt[k], (k == pkt.size() - 1) ? 1'b1 : 1'b0});
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input ab2lp_pkg::in_item_t it, input logic typed,
			input ab2lp_pkg::out_item_t exp);
		while (!no_idle && $urandom_range(99) < 38) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		typed_use = typed;
		typed_rec = exp;
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		result_ready <= no_idle || ($urandom_range(99) >= 38);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// request prediction first, then result check, in one process per edge
	always @(posedge clk) begin
		ab2lp_pkg::out_item_t exp;
		if (arst_n && item_valid && item_ready) begin
			strip_byte(item);
			if (typed_use) begin
				pending_records.push_back(typed_rec);
			end else begin
				foreach (step_recs[k]) begin
					exp = step_recs[k];
					exp.run_last = (k == step_recs.size() - 1) ? 1'b1 : 1'b0;
					pending_records.push_back(exp);
				end
			end
		end
		if (arst_n && result_valid && result_ready) begin
			if (pending_records.size() == 0) begin
				report_fault($sformatf("unexpected result kind %0d byte %h len %0d last %b",
					result.record_kind, result.payload_byte, result.unit_length,
					result.run_last));
			end else begin
				exp = pending_records.pop_front();
				if (result.record_kind !== exp.record_kind
						|| result.payload_byte !== exp.payload_byte
						|| result.unit_length !== exp.unit_length
						|| result.run_last !== exp.run_last)
					report_fault($sformatf(
						"mismatch exp kind %0d byte %h len %0d last %b, got %0d %h %0d %b",
						exp.record_kind, exp.payload_byte, exp.unit_length, exp.run_last,
						result.record_kind, result.payload_byte, result.unit_length,
						result.run_last));
			end
		end
	end

	initial begin
		int i;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_ready = 1'b0;
		typed_use    = 1'b0;
		typed_rec    = '0;
		no_idle      = 1'b0;
		fault_count  = 0;
		cycles       = 0;
		zero_run     = 0;
		in_unit      = 1'b0;
		unit_len     = 32'd0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < SCRIPT_LEN; i++)
			send_item(script[i].stim, script[i].typed, script[i].exp);

		while (stim_q.size() < RANDOM_ITEMS)
			queue_packet();
		for (i = 0; i < stim_q.size(); i++) begin
			// a stretch with both sides always willing
			if (i == 120)
				no_idle <= 1'b1;
			if (i == 200)
				no_idle <= 1'b0;
			send_item(stim_q[i], 1'b0, '0);
		end
		item_valid <= 1'b0;

		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0 && pending_records.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
